@@ rtl/lrupr_pkg.sv @@
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared constants and types for the LRU page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    // Built frame count and stored page width defaults
    localparam int FRAME_COUNT_DEF = 8;
    localparam int PAGE_BITS_DEF   = 16;

    // Fixed field widths
    localparam int PAGE_PORT_W = 16;
    localparam int CFG_W       = 4;
    localparam int COUNT_W     = 32;

    // Active frame count after reset
    localparam logic [CFG_W-1:0] ACTIVE_FRAMES_RST = 4'd8;

    // Per-reference control broadcast to every cell
    typedef struct packed {
        logic update;
        logic hit_any;
        logic empty_any;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ rtl/lrupr_cell.sv @@
// ----------------------------------------------------------------------------
// lrupr_cell
// One recency slot: holds a page and its valid flag, compares against the
// reference and takes its upper neighbor's entry when the order shifts down.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_cell #(
    parameter int   PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    parameter logic IS_BASE   = 1'b0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire lrupr_pkg::t_cell_ctrl  i_ctrl,
    input  wire logic [PAGE_BITS-1:0]   i_page,
    input  wire logic                   i_window,
    input  wire logic                   i_top,
    input  wire logic                   i_shift_in,
    input  wire logic [PAGE_BITS-1:0]   i_next_page,
    input  wire logic                   i_next_valid,
    output logic                        o_shift_out,
    output logic                        o_match,
    output logic                        o_empty,
    output logic [PAGE_BITS-1:0]        o_page,
    output logic                        o_valid
);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic                 w_cand;
    logic                 w_shift;
    logic                 w_load;

    // Compare against the reference inside the active window
    assign o_match = i_window & r_valid & (r_page == i_page);
    assign o_empty = i_window & ~r_valid;

    // Pick the slot to remove: lowest hit, else lowest empty, else the base
    always_comb begin
        priority if (i_ctrl.hit_any) begin
            w_cand = o_match;
        end else if (i_ctrl.empty_any) begin
            w_cand = o_empty;
        end else begin
            w_cand = IS_BASE & i_window;
        end
    end

    // Propagate the shift mark upward from the removed slot
    assign w_shift     = i_shift_in | w_cand;
    assign o_shift_out = w_shift;
    assign w_load      = i_ctrl.update & i_window;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            if (i_top) begin
                r_valid <= 1'b1;
            end else if (w_shift) begin
                r_valid <= i_next_valid;
            end
        end
    end

    // Hold the page
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (i_top) begin
                r_page <= i_page;
            end else if (w_shift) begin
                r_page <= i_next_page;
            end
        end
    end

    assign o_page  = r_page;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

@@ rtl/lrupr_counter.sv @@
// ----------------------------------------------------------------------------
// lrupr_counter
// Saturating event counter for hit and miss totals.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_counter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_inc,
    output logic [lrupr_pkg::COUNT_W-1:0]      o_count
);

    logic [lrupr_pkg::COUNT_W-1:0] r_count;
    logic [lrupr_pkg::COUNT_W-1:0] n_count;

    // Advance unless already at the top
    always_comb begin
        n_count = r_count;
        if (i_inc && (r_count != {lrupr_pkg::COUNT_W{1'b1}})) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

@@ rtl/lru_page_replacement_top.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// Fully associative LRU frame set built as a row of recency cells.
// The result of a reference appears with o_done in the cycle after the
// transaction is accepted. Throughput: one reference per cycle; busy is
// never raised, since the cell row compares and shifts in the accepting
// cycle. The receiver cannot stall. Reset empties all frames, clears both
// totals and sets the active frame count to 8, clamped at the built count.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_top #(
    parameter int FRAME_COUNT = lrupr_pkg::FRAME_COUNT_DEF,
    parameter int PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [lrupr_pkg::PAGE_PORT_W-1:0]  i_page_number,
    input  wire logic                               i_cfg_we,
    input  wire logic [lrupr_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                                    o_done,
    output logic                                    o_hit,
    output logic                                    o_evicted_valid,
    output logic [lrupr_pkg::PAGE_PORT_W-1:0]       o_evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]           o_hit_total,
    output logic [lrupr_pkg::COUNT_W-1:0]           o_miss_total
);

    localparam int NW = $clog2(FRAME_COUNT + 1);
    localparam int EW = (NW > lrupr_pkg::CFG_W) ? NW : lrupr_pkg::CFG_W;

    // Effective frame count: zero acts as one, clamp at the built count
    function automatic logic [EW-1:0] eff_frames(input logic [lrupr_pkg::CFG_W-1:0] cfg);
        logic [EW-1:0] v;
        v = EW'(cfg);
        if (v == '0) begin
            v = EW'(1);
        end else if (v > EW'(FRAME_COUNT)) begin
            v = EW'(FRAME_COUNT);
        end
        return v;
    endfunction

    function automatic logic [FRAME_COUNT-1:0] window_mask(
        input logic [lrupr_pkg::CFG_W-1:0] cfg
    );
        logic [EW-1:0]          n;
        logic [FRAME_COUNT-1:0] m;
        n = eff_frames(cfg);
        for (int i = 0; i < FRAME_COUNT; i++) begin
            m[i] = (EW'(i) < n);
        end
        return m;
    endfunction

    function automatic logic [FRAME_COUNT-1:0] top_mask(
        input logic [lrupr_pkg::CFG_W-1:0] cfg
    );
        logic [EW-1:0]          n;
        logic [FRAME_COUNT-1:0] m;
        n = eff_frames(cfg);
        for (int i = 0; i < FRAME_COUNT; i++) begin
            m[i] = (EW'(i) == (n - EW'(1)));
        end
        return m;
    endfunction

    logic [FRAME_COUNT-1:0] r_window;
    logic [FRAME_COUNT-1:0] r_top;

    logic                   w_accept;
    logic [PAGE_BITS-1:0]   w_page;
    lrupr_pkg::t_cell_ctrl  w_ctrl;

    logic [FRAME_COUNT-1:0] w_match;
    logic [FRAME_COUNT-1:0] w_empty;
    logic [FRAME_COUNT-1:0] w_valid;
    logic [FRAME_COUNT:0]   w_shift;
    logic [PAGE_BITS-1:0]   w_pages [FRAME_COUNT];

    logic [lrupr_pkg::PAGE_PORT_W-1:0] w_base_page;
    logic                   w_evict;

    logic                   r_done;
    logic                   r_hit;
    logic                   r_ev_valid;
    logic [lrupr_pkg::PAGE_PORT_W-1:0] r_ev_page;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    // Hold the decoded frame window; rebuild it on a configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= window_mask(lrupr_pkg::ACTIVE_FRAMES_RST);
            r_top    <= top_mask(lrupr_pkg::ACTIVE_FRAMES_RST);
        end else if (i_cfg_we) begin
            r_window <= window_mask(i_cfg_data);
            r_top    <= top_mask(i_cfg_data);
        end
    end

    // Fit the referenced page to the stored width
    generate
        if (PAGE_BITS <= lrupr_pkg::PAGE_PORT_W) begin : g_page_narrow
            assign w_page = i_page_number[PAGE_BITS-1:0];
        end else begin : g_page_wide
            assign w_page = {{(PAGE_BITS - lrupr_pkg::PAGE_PORT_W){1'b0}}, i_page_number};
        end
    endgenerate

    assign w_ctrl.update    = w_accept;
    assign w_ctrl.hit_any   = |w_match;
    assign w_ctrl.empty_any = |w_empty;

    assign w_shift[0] = 1'b0;

    // Row of recency cells, least recent at index 0
    generate
        for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
            logic [PAGE_BITS-1:0] w_next_page;
            logic                 w_next_valid;

            if (i == FRAME_COUNT - 1) begin : g_last
                assign w_next_page  = '0;
                assign w_next_valid = 1'b0;
            end else begin : g_mid
                assign w_next_page  = w_pages[i+1];
                assign w_next_valid = w_valid[i+1];
            end

            lrupr_cell #(
                .PAGE_BITS (PAGE_BITS),
                .IS_BASE   ((i == 0) ? 1'b1 : 1'b0)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_page       (w_page),
                .i_window     (r_window[i]),
                .i_top        (r_top[i]),
                .i_shift_in   (w_shift[i]),
                .i_next_page  (w_next_page),
                .i_next_valid (w_next_valid),
                .o_shift_out  (w_shift[i+1]),
                .o_match      (w_match[i]),
                .o_empty      (w_empty[i]),
                .o_page       (w_pages[i]),
                .o_valid      (w_valid[i])
            );
        end
    endgenerate

    // Fit the base slot page to the result width
    generate
        if (PAGE_BITS >= lrupr_pkg::PAGE_PORT_W) begin : g_ev_wide
            assign w_base_page = w_pages[0][lrupr_pkg::PAGE_PORT_W-1:0];
        end else begin : g_ev_narrow
            assign w_base_page = {{(lrupr_pkg::PAGE_PORT_W - PAGE_BITS){1'b0}}, w_pages[0]};
        end
    endgenerate

    // A full window on a miss drops the least recent page
    assign w_evict = ~w_ctrl.hit_any & ~w_ctrl.empty_any;

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_accept;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit      <= w_ctrl.hit_any;
            r_ev_valid <= w_evict;
            r_ev_page  <= w_evict ? w_base_page : '0;
        end
    end

    // Running totals
    lrupr_counter u_hit_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (w_accept & w_ctrl.hit_any),
        .o_count (o_hit_total)
    );

    lrupr_counter u_miss_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (w_accept & ~w_ctrl.hit_any),
        .o_count (o_miss_total)
    );

    assign o_done          = r_done;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;

endmodule

`default_nettype wire
